>>> hw/rtl/sfrx_pkg.sv
// Shared types and constants for the serial frame receiver.
package sfrx_pkg;

    localparam int DATA_BYTES_DEF = 10;
    localparam logic [7:0] START_BYTE = 8'd255;

    typedef enum logic [1:0] {
        KIND_MSG       = 2'd0,
        KIND_BAD_START = 2'd1,
        KIND_PARITY    = 2'd2
    } t_kind;

    typedef enum logic {
        RX_IDLE  = 1'b0,
        RX_FRAME = 1'b1
    } t_rx_state;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] payload;
        logic       last;
    } t_result;

    // Front-to-back queue request
    typedef struct packed {
        logic    wr_en;      // write entry
        logic    at_commit;  // write at commit point and commit it (drops open frame)
        logic    commit;     // commit all speculative entries
        t_result entry;
    } t_wr_req;

endpackage

>>> hw/rtl/sfrx_front.sv
// Front end: frame tracking, incremental parity check, queue requests.
module sfrx_front #(
    parameter int DATA_BYTES = sfrx_pkg::DATA_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_byte,
    input  logic             i_space,
    output logic             o_ready,
    output sfrx_pkg::t_wr_req o_req
);

    localparam int PAIRS       = DATA_BYTES / 2;
    localparam int PARITY_BASE = 3 + DATA_BYTES;
    localparam int FRAME_LEN   = PARITY_BASE + PAIRS;
    localparam int POS_W       = $clog2(FRAME_LEN);
    localparam int PAIR_W      = (PAIRS > 1) ? $clog2(PAIRS) : 1;

    sfrx_pkg::t_rx_state r_state, n_state;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic                r_bad, n_bad;
    logic [7:0]          r_prev;
    logic [7:0]          r_pair [PAIRS];

    logic               accept;
    logic [POS_W-1:0]   pos_m3;
    logic [POS_W-1:0]   pos_mpb;
    logic [PAIR_W-1:0]  pair_wr_idx;
    logic [PAIR_W-1:0]  pair_rd_idx;
    logic               is_data;
    logic               is_last_data;
    logic               is_pair_end;
    logic               is_parity;
    logic               is_final;
    logic               frame_bad;

    assign o_ready = i_space;
    assign accept  = i_valid && i_space;

    assign pos_m3      = r_pos - POS_W'(3);
    assign pos_mpb     = r_pos - POS_W'(PARITY_BASE);
    assign pair_wr_idx = PAIR_W'(pos_m3 >> 1);
    assign pair_rd_idx = PAIR_W'(pos_mpb);

    assign is_data      = (r_pos >= POS_W'(1)) && (r_pos <= POS_W'(DATA_BYTES + 1));
    assign is_last_data = (r_pos == POS_W'(DATA_BYTES + 1));
    assign is_pair_end  = r_pos[0] && (r_pos >= POS_W'(3)) && (r_pos <= POS_W'(2 * PAIRS + 1));
    assign is_parity    = (r_pos >= POS_W'(PARITY_BASE));
    assign is_final     = (r_pos == POS_W'(FRAME_LEN - 1));

    // sticky mismatch including the byte now arriving
    assign frame_bad = r_bad || (is_parity && (r_pair[pair_rd_idx] != i_byte));

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_bad   = r_bad;
        case (r_state)
            sfrx_pkg::RX_IDLE: begin
                if (accept && (i_byte == sfrx_pkg::START_BYTE)) begin
                    n_state = sfrx_pkg::RX_FRAME;
                    n_pos   = POS_W'(1);
                    n_bad   = 1'b0;
                end
            end
            sfrx_pkg::RX_FRAME: begin
                if (accept) begin
                    n_bad = frame_bad;
                    if (is_final) begin
                        n_state = sfrx_pkg::RX_IDLE;
                        n_pos   = '0;
                    end else begin
                        n_pos = r_pos + POS_W'(1);
                    end
                end
            end
            default: begin
                n_state = sfrx_pkg::RX_IDLE;
                n_pos   = '0;
            end
        endcase
    end

    always_comb begin
        o_req               = '0;
        o_req.entry.kind    = sfrx_pkg::KIND_MSG;
        case (r_state)
            sfrx_pkg::RX_IDLE: begin
                if (accept && (i_byte != sfrx_pkg::START_BYTE)) begin
                    o_req.wr_en      = 1'b1;
                    o_req.at_commit  = 1'b1;
                    o_req.entry.kind = sfrx_pkg::KIND_BAD_START;
                    o_req.entry.last = 1'b1;
                end
            end
            sfrx_pkg::RX_FRAME: begin
                if (accept && is_data) begin
                    o_req.wr_en         = 1'b1;
                    o_req.entry.payload = i_byte;
                    o_req.entry.last    = is_last_data;
                end
                if (accept && is_final) begin
                    if (frame_bad) begin
                        o_req.wr_en      = 1'b1;
                        o_req.at_commit  = 1'b1;
                        o_req.entry.kind = sfrx_pkg::KIND_PARITY;
                        o_req.entry.last = 1'b1;
                    end else begin
                        o_req.commit = 1'b1;
                    end
                end
            end
            default: begin
                o_req = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfrx_pkg::RX_IDLE;
            r_pos   <= '0;
            r_bad   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_bad   <= n_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prev <= i_byte;
            if ((r_state == sfrx_pkg::RX_FRAME) && is_pair_end) begin
                r_pair[pair_wr_idx] <= r_prev ^ i_byte;
            end
        end
    end

endmodule

>>> hw/rtl/sfrx_back.sv
// Back end: result queue with speculative writes and commit, plus output register.
module sfrx_back #(
    parameter int DATA_BYTES = sfrx_pkg::DATA_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sfrx_pkg::t_wr_req i_req,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output sfrx_pkg::t_result o_result
);

    // room for one committed run plus one open frame
    localparam int DEPTH = 2 ** $clog2(2 * (DATA_BYTES + 1));
    localparam int IDX_W = $clog2(DEPTH);
    localparam int PTR_W = IDX_W + 1;

    sfrx_pkg::t_result mem [DEPTH];

    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_cm;
    logic [PTR_W-1:0]  r_rd;
    logic              r_vld;
    sfrx_pkg::t_result r_out;

    logic [PTR_W-1:0] wr_addr;
    logic [PTR_W-1:0] used;
    logic             load;

    assign used    = r_wr - r_rd;
    assign o_space = (used != PTR_W'(DEPTH));
    assign wr_addr = i_req.at_commit ? r_cm : r_wr;
    assign load    = (r_rd != r_cm) && (!r_vld || i_ready);

    assign o_valid  = r_vld;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[wr_addr[IDX_W-1:0]] <= i_req.entry;
        end
        if (load) begin
            r_out <= mem[r_rd[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_cm  <= '0;
            r_rd  <= '0;
            r_vld <= 1'b0;
        end else begin
            if (i_req.wr_en && i_req.at_commit) begin
                // discards any open frame entries
                r_cm <= r_cm + PTR_W'(1);
                r_wr <= r_cm + PTR_W'(1);
            end else if (i_req.wr_en) begin
                r_wr <= r_wr + PTR_W'(1);
            end else if (i_req.commit) begin
                r_cm <= r_wr;
            end
            if (load) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            r_vld <= load || (r_vld && !i_ready);
        end
    end

endmodule

>>> hw/rtl/serial_frame_receiver_xor_check.sv
// Top level of the serial frame receiver with XOR parity check.
//
// Slave stream: one received byte per request on s_axis_tdata. Idle, a byte of
// 255 opens a frame; any other byte yields a bad-start error result. A frame is
// 3 + DATA_BYTES + DATA_BYTES/2 bytes: start, descriptor, data, header check
// (ignored) and parity bytes, each the XOR of a data pair.
// Master stream: tdata = payload byte, tuser = kind (0 message, 1 bad start,
// 2 parity error), tlast = end of message run or error. A good frame gives
// DATA_BYTES+1 message results, a bad one a single parity error.
// Throughput: one input byte per cycle while s_axis_tready is high, and one
// result per cycle while m_axis_tready is high and committed results wait.
// Data bytes are queued as they arrive and released, or dropped, on the final
// byte, so a run drains while the next frame comes in. The queue holds two
// runs; when it is full s_axis_tready drops and only a stalled master side
// can cause that. Reset returns to idle with an empty queue, no clearing pass.
module serial_frame_receiver_xor_check #(
    parameter int DATA_BYTES = sfrx_pkg::DATA_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
    output logic [1:0] m_axis_tuser,   // [1:0] kind
    output logic       m_axis_tlast
);

    sfrx_pkg::t_wr_req req;
    sfrx_pkg::t_result result;
    logic              space;

    sfrx_front #(
        .DATA_BYTES(DATA_BYTES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_byte  (s_axis_tdata),
        .i_space (space),
        .o_ready (s_axis_tready),
        .o_req   (req)
    );

    sfrx_back #(
        .DATA_BYTES(DATA_BYTES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (req),
        .o_space  (space),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    assign m_axis_tdata = result.payload;
    assign m_axis_tuser = result.kind;
    assign m_axis_tlast = result.last;

endmodule

>>> tb/tb_serial_frame_receiver_xor_check.sv
// Self-checking testbench for the serial frame receiver with XOR parity check.
`timescale 1ns / 100ps

module tb_serial_frame_receiver_xor_check;

    localparam int DATA_BYTES   = sfrx_pkg::DATA_BYTES_DEF;
    localparam int PARITY_BYTES = DATA_BYTES / 2;
    localparam int FRAME_LEN    = 3 + DATA_BYTES + PARITY_BYTES;
    localparam int PARITY_BASE  = 3 + DATA_BYTES;
    localparam int RANDOM_ITEMS = 300;
    localparam int HOLD_CYCLES  = 1000;
    localparam int HOLD_AFTER   = 30;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 20;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'd0;   // [7:0] rx_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;          // [7:0] payload_byte
    logic [1:0] m_axis_tuser;          // [1:0] kind
    logic       m_axis_tlast;

    serial_frame_receiver_xor_check #(
        .DATA_BYTES(DATA_BYTES)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Receiver state mirror
    sfrx_pkg::t_rx_state rx_state = sfrx_pkg::RX_IDLE;
    logic [7:0] frame_bytes [FRAME_LEN];
    int         frame_pos = 0;

    logic [7:0]        rx_stream [$];
    sfrx_pkg::t_result expected_results [$];
    logic [7:0]        frame_data [DATA_BYTES];

    int   errors = 0;
    int   results_seen = 0;
    int   send_gap = 0;
    logic send_burst = 1'b0;
    int   stall_left = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;
    logic recv_burst = 1'b0;
    int   idle_cycles = 0;

    function automatic int draw_wait(input logic burst);
        return burst ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic sfrx_pkg::t_result make_result(input sfrx_pkg::t_kind kind,
                                                      input logic [7:0] payload,
                                                      input logic last);
        sfrx_pkg::t_result r;
        r.kind    = kind;
        r.payload = payload;
        r.last    = last;
        return r;
    endfunction

    // Expected results caused by one accepted byte
    function void predict_rx_byte(input logic [7:0] b);
        logic parity_ok;
        if (rx_state == sfrx_pkg::RX_IDLE) begin
            if (b == sfrx_pkg::START_BYTE) begin
                frame_bytes[0] = b;
                frame_pos      = 1;
                rx_state       = sfrx_pkg::RX_FRAME;
            end else begin
                expected_results.push_back(make_result(sfrx_pkg::KIND_BAD_START, 8'd0, 1'b1));
            end
        end else begin
            frame_bytes[frame_pos] = b;
            frame_pos++;
            if (frame_pos == FRAME_LEN) begin
                rx_state  = sfrx_pkg::RX_IDLE;
                frame_pos = 0;
                parity_ok = 1'b1;
                // odd DATA_BYTES: the last data byte belongs to no pair
                for (int p = 0; p < PARITY_BYTES; p++)
                    if ((frame_bytes[2 + 2 * p] ^ frame_bytes[3 + 2 * p])
                            != frame_bytes[PARITY_BASE + p])
                        parity_ok = 1'b0;
                if (!parity_ok)
                    expected_results.push_back(make_result(sfrx_pkg::KIND_PARITY, 8'd0, 1'b1));
                else
                    for (int k = 0; k <= DATA_BYTES; k++)
                        expected_results.push_back(make_result(sfrx_pkg::KIND_MSG,
                                                               frame_bytes[k + 1],
                                                               k == DATA_BYTES));
            end
        end
    endfunction

    // Build one frame from frame_data; bad_pair >= 0 corrupts that parity byte
    task automatic queue_frame(input logic [7:0] descriptor, input logic [7:0] hdr_check,
                               input int bad_pair);
        logic [7:0] f [FRAME_LEN];
        f[0] = sfrx_pkg::START_BYTE;
        f[1] = descriptor;
        for (int i = 0; i < DATA_BYTES; i++)
            f[2 + i] = frame_data[i];
        f[2 + DATA_BYTES] = hdr_check;
        for (int p = 0; p < PARITY_BYTES; p++)
            f[PARITY_BASE + p] = f[2 + 2 * p] ^ f[3 + 2 * p];
        if (bad_pair >= 0)
            f[PARITY_BASE + bad_pair] ^= 8'($urandom_range(1, 255));
        for (int i = 0; i < FRAME_LEN; i++)
            rx_stream.push_back(f[i]);
    endtask

    // Sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap      <= 0;
        end else if (!(s_axis_tvalid && !s_axis_tready)) begin
            if (s_axis_tvalid)
                predict_rx_byte(s_axis_tdata);
            if ($urandom_range(0, 31) == 0)
                send_burst <= !send_burst;
            if (send_gap != 0) begin
                s_axis_tvalid <= 1'b0;
                send_gap      <= send_gap - 1;
            end else if (rx_stream.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= rx_stream.pop_front();
                send_gap      <= draw_wait(send_burst);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver and result check
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result: kind %0d payload %0h last %0b",
                           m_axis_tuser, m_axis_tdata, m_axis_tlast);
                    errors++;
                end else begin
                    sfrx_pkg::t_result exp_r;
                    exp_r = expected_results.pop_front();
                    if (m_axis_tuser != exp_r.kind) begin
                        $error("kind: expected %0d, got %0d", exp_r.kind, m_axis_tuser);
                        errors++;
                    end
                    if (m_axis_tdata != exp_r.payload) begin
                        $error("payload_byte: expected %0h, got %0h",
                               exp_r.payload, m_axis_tdata);
                        errors++;
                    end
                    if (m_axis_tlast != exp_r.last) begin
                        $error("last: expected %0b, got %0b", exp_r.last, m_axis_tlast);
                        errors++;
                    end
                end
            end
            if ($urandom_range(0, 31) == 0)
                recv_burst <= !recv_burst;
            // one long hold-off so the result queue fills and backs up the input
            if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_done     <= 1'b1;
                hold_left     <= HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (m_axis_tvalid && m_axis_tready) begin
                int n;
                n = draw_wait(recv_burst);
                m_axis_tready <= (n == 0);
                stall_left    <= (n == 0) ? 0 : n - 1;
            end else if (stall_left != 0) begin
                stall_left    <= stall_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no request moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_serial_frame_receiver_xor_check failed");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        int sel;
        int bad_pair;
        int n_noise;

        // Directed: bad starts at both extremes, then a frame whose descriptor and
        // data carry 255 and 0, with an untested header-check byte
        rx_stream.push_back(8'h00);
        rx_stream.push_back(8'hFE);
        frame_data = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA, 8'h0F, 8'hF0};
        queue_frame(8'hFF, 8'hC3, -1);
        // same data, one parity byte wrong
        queue_frame(8'h00, 8'h3C, PARITY_BYTES - 1);

        while (rx_stream.size() < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 9);
            if (sel <= 7) begin
                for (int i = 0; i < DATA_BYTES; i++)
                    frame_data[i] = 8'($urandom_range(0, 255));
                bad_pair = (sel >= 6) ? int'($urandom_range(0, PARITY_BYTES - 1)) : -1;
                queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), bad_pair);
            end else begin
                n_noise = $urandom_range(1, 3);
                repeat (n_noise) rx_stream.push_back(8'($urandom_range(0, 254)));
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (rx_stream.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0)
            $display("tb_serial_frame_receiver_xor_check passed");
        else
            $display("tb_serial_frame_receiver_xor_check failed");
        $finish;
    end

endmodule
